// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Session slot table package
// Request and response payload types, request modes and status codes.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam logic [1:0] MODE_CREATE  = 2'd0;
  localparam logic [1:0] MODE_DESTROY = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOROOM   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [2:0] POLICY_MAX = 3'd3;

  localparam int IdW   = 64;
  localparam int PrioW = 32;

  typedef struct packed {
    logic [1:0]              mode;
    logic [IdW-1:0]          session_id;
    logic signed [PrioW-1:0] priority_req;
    logic [2:0]              policy;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] new_id;
    logic           is_active;
    logic           best_valid;
    logic [3:0]     best_slot;
    logic [4:0]     active_count;
  } rsp_t;

endpackage

// ===== rtl/session_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// Session slot table
// Allocates, frees and looks up sessions in a fixed slot table and reports
// the active count and the highest-priority active slot with each response.
// ----------------------------------------------------------------------------
// A request is accepted only while idle; the next one is not taken until
//   the response is issued after a single pass over the slot memory, one
//   entry per cycle through its one read port.
// A response left waiting on out_ready holds the block in its final step.
// Reset: all slots inactive, id counter at 1, active count at 0; slot ids and
//   priorities are not cleared and are only read for active slots.
// ----------------------------------------------------------------------------
module session_slot_table_top #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sst_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::rsp_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = sst_pkg::IdW + sst_pkg::PrioW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  sst_pkg::req_t                   req_r, req_nxt;
  logic [SLOTS-1:0]                slot_active_r, slot_active_nxt;
  logic [sst_pkg::IdW-1:0]         id_counter_r, id_counter_nxt;
  logic [CW-1:0]                   live_count_r, live_count_nxt;
  logic [CW-1:0]                   issue_cnt_r, issue_cnt_nxt;
  logic [IW-1:0]                   chk_idx_r;
  logic                            pipe_v_r, pipe_v_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [IW-1:0]                   free_idx_r, free_idx_nxt;
  logic                            match_found_r, match_found_nxt;
  logic [IW-1:0]                   match_idx_r, match_idx_nxt;
  logic                            best_valid_r, best_valid_nxt;
  logic [IW-1:0]                   best_idx_r, best_idx_nxt;
  logic signed [sst_pkg::PrioW-1:0] best_prio_r, best_prio_nxt;
  logic                            out_valid_r, out_valid_nxt;
  sst_pkg::rsp_t                   out_data_r, out_data_nxt;

  logic [MW-1:0]                   slot_mem [SLOTS];
  logic [MW-1:0]                   rd_data_r;
  logic                            mem_we;

  logic [sst_pkg::IdW-1:0]         rd_ident;
  logic signed [sst_pkg::PrioW-1:0] rd_prio;
  logic signed [sst_pkg::PrioW-1:0] eff_prio;
  logic                            cur_active;
  logic                            id_hit;
  logic                            create_ok;
  logic                            destroy_ok;
  logic                            query_ok;
  logic                            take_free;
  logic                            drop;
  logic                            eff_active;
  logic                            better;
  logic                            issuing;
  logic                            out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_ident   = rd_data_r[MW-1:sst_pkg::PrioW];
  assign rd_prio    = signed'(rd_data_r[sst_pkg::PrioW-1:0]);
  assign cur_active = slot_active_r[chk_idx_r];
  assign id_hit     = cur_active && (rd_ident == req_r.session_id);

  assign create_ok  = (req_r.mode == sst_pkg::MODE_CREATE) &&
                      (req_r.policy <= sst_pkg::POLICY_MAX);
  assign destroy_ok = (req_r.mode == sst_pkg::MODE_DESTROY) && (req_r.session_id != '0);
  assign query_ok   = (req_r.mode == sst_pkg::MODE_QUERY) && (req_r.session_id != '0);

  // The slot seen first in index order is the one a create fills or a
  // destroy frees, so the best-slot search can see the post-request table.
  assign take_free  = create_ok && !free_found_r && !cur_active;
  assign drop       = destroy_ok && !match_found_r && id_hit;
  assign eff_active = take_free || (cur_active && !drop);
  assign eff_prio   = take_free ? req_r.priority_req : rd_prio;
  assign better     = eff_active && (!best_valid_r || (eff_prio > best_prio_r));

  assign issuing  = (issue_cnt_r < CW'(SLOTS));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    slot_active_nxt = slot_active_r;
    id_counter_nxt  = id_counter_r;
    live_count_nxt  = live_count_r;
    issue_cnt_nxt   = issue_cnt_r;
    pipe_v_nxt      = 1'b0;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    best_valid_nxt  = best_valid_r;
    best_idx_nxt    = best_idx_r;
    best_prio_nxt   = best_prio_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt         = in_data;
          issue_cnt_nxt   = '0;
          free_found_nxt  = 1'b0;
          free_idx_nxt    = '0;
          match_found_nxt = 1'b0;
          match_idx_nxt   = '0;
          best_valid_nxt  = 1'b0;
          best_idx_nxt    = '0;
          best_prio_nxt   = '0;
          state_nxt       = S_SCAN;
        end
      end

      S_SCAN: begin
        if (issuing) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          pipe_v_nxt    = 1'b1;
        end
        if (pipe_v_r) begin
          if (take_free) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if ((destroy_ok || query_ok) && !match_found_r && id_hit) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = chk_idx_r;
          end
          if (better) begin
            best_valid_nxt = 1'b1;
            best_idx_nxt   = chk_idx_r;
            best_prio_nxt  = eff_prio;
          end
          if (chk_idx_r == IW'(SLOTS - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_data_nxt           = '0;
          out_data_nxt.best_valid = best_valid_r;
          out_data_nxt.best_slot  = 4'(best_idx_r);
          case (req_r.mode)
            sst_pkg::MODE_CREATE: begin
              if (!create_ok) begin
                out_data_nxt.status = sst_pkg::ST_INVALID;
              end else if (!free_found_r) begin
                out_data_nxt.status = sst_pkg::ST_NOROOM;
              end else begin
                out_data_nxt.status         = sst_pkg::ST_OK;
                out_data_nxt.new_id         = id_counter_r;
                slot_active_nxt[free_idx_r] = 1'b1;
                id_counter_nxt              = id_counter_r + 1'b1;
                live_count_nxt              = live_count_r + 1'b1;
                mem_we                      = 1'b1;
              end
            end
            sst_pkg::MODE_DESTROY: begin
              if (!destroy_ok) begin
                out_data_nxt.status = sst_pkg::ST_INVALID;
              end else if (!match_found_r) begin
                out_data_nxt.status = sst_pkg::ST_NOTFOUND;
              end else begin
                out_data_nxt.status          = sst_pkg::ST_OK;
                slot_active_nxt[match_idx_r] = 1'b0;
                if (live_count_r != '0) begin
                  live_count_nxt = live_count_r - 1'b1;
                end
              end
            end
            sst_pkg::MODE_QUERY: begin
              out_data_nxt.status    = sst_pkg::ST_OK;
              out_data_nxt.is_active = match_found_r;
            end
            default: begin
              out_data_nxt.status = sst_pkg::ST_INVALID;
            end
          endcase
          out_data_nxt.active_count = 5'(live_count_nxt);
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_active_r <= '0;
      id_counter_r  <= sst_pkg::IdW'(1);
      live_count_r  <= '0;
      pipe_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slot_active_r <= slot_active_nxt;
      id_counter_r  <= id_counter_nxt;
      live_count_r  <= live_count_nxt;
      pipe_v_r      <= pipe_v_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    req_r         <= req_nxt;
    issue_cnt_r   <= issue_cnt_nxt;
    chk_idx_r     <= issue_cnt_r[IW-1:0];
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    best_valid_r  <= best_valid_nxt;
    best_idx_r    <= best_idx_nxt;
    best_prio_r   <= best_prio_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Slot id and priority store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[free_idx_r] <= {id_counter_r, req_r.priority_req};
    end
    rd_data_r <= slot_mem[issue_cnt_r[IW-1:0]];
  end

endmodule
